FILE: design/vist_pkg.sv
// ----------------------------------------------------------------------------
// vist_pkg: shared types and constants for the voxel sphere-union test
// widths of the fixed-point datapath, register indexes and stage controls
// ----------------------------------------------------------------------------
package vist_pkg;

  // number of centre cells
  localparam int MAX_CENTERS = 16;

  // field widths
  localparam int COORD_W = 24;  // centre coordinate, signed Q15.8
  localparam int VOX_W   = 20;  // voxel index, signed integer
  localparam int VSIZE_W = 16;  // voxel size, unsigned Q8.8
  localparam int RAD_W   = 63;  // radius squared, unsigned Q.18
  localparam int CNT_W   = 5;   // active centre count
  localparam int IDX_W   = 4;   // centre slot index
  localparam int CFG_A_W = 2;   // config register index
  localparam int CFG_D_W = 63;  // config write data

  // datapath widths
  localparam int VC_W  = 37;  // voxel centre, signed Q.9
  localparam int DLT_W = 38;  // centre delta, signed Q.9
  localparam int MAG_W = 32;  // unsaturated delta magnitude
  localparam int SQ_W  = 64;  // squared delta, Q.18
  localparam int SUM_W = 66;  // sum of three squares, no overflow

  // register indexes
  localparam logic [CFG_A_W-1:0] CFG_VOXEL_SIZE     = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_RADIUS_SQUARED = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_CENTER_COUNT   = 2'd2;

  localparam logic [VSIZE_W-1:0] VOXEL_SIZE_RST = 16'd256;

  // item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TEST  = 1'b1;

  typedef logic [2:0][COORD_W-1:0] coord3_t;
  typedef logic [2:0][VC_W-1:0]    vc3_t;
  typedef logic [SUM_W-1:0]        sum_t;

  // per-cycle stage controls handed to every centre cell
  typedef struct packed {
    logic wr;  // store the write beat leaving stage 1
    logic en2; // load delta magnitude stage
    logic en3; // load square stage
    logic en4; // load sum stage
  } adv_t;

endpackage

FILE: design/vist_lane.sv
// ----------------------------------------------------------------------------
// vist_lane: one centre cell
// holds one table entry and runs delta, square and sum stages against it
// ----------------------------------------------------------------------------
module vist_lane (
  input  logic             clk,
  input  vist_pkg::adv_t   adv,
  input  vist_pkg::coord3_t wr_center,
  input  vist_pkg::vc3_t   vc,
  output vist_pkg::sum_t   sum_r,
  output logic             big_r
);
  import vist_pkg::*;

  coord3_t                entry_r;
  logic [2:0][MAG_W-1:0]  mag_r;
  logic                   big2_r;
  logic [2:0][SQ_W-1:0]   sq_r;
  logic                   big3_r;

  logic [2:0][MAG_W-1:0]  mag_nxt;
  logic                   big2_nxt;

  // delta in Q.9: voxel centre minus twice the stored centre
  always_comb begin
    logic [DLT_W-1:0] d;
    logic [DLT_W-1:0] a;
    big2_nxt = 1'b0;
    for (int k = 0; k < 3; k++) begin
      d = {vc[k][VC_W-1], vc[k]}
        - {{(DLT_W-COORD_W-1){entry_r[k][COORD_W-1]}}, entry_r[k], 1'b0};
      a = d[DLT_W-1] ? (~d + DLT_W'(1)) : d;
      mag_nxt[k] = a[MAG_W-1:0];
      // a magnitude of 2^32 or more squares past the saturation point
      big2_nxt = big2_nxt | (|a[DLT_W-1:MAG_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.wr) begin
      entry_r <= wr_center;
    end
    if (adv.en2) begin
      mag_r  <= mag_nxt;
      big2_r <= big2_nxt;
    end
    if (adv.en3) begin
      for (int k = 0; k < 3; k++) begin
        sq_r[k] <= mag_r[k] * mag_r[k];
      end
      big3_r <= big2_r;
    end
    if (adv.en4) begin
      sum_r <= {2'b00, sq_r[0]} + {2'b00, sq_r[1]} + {2'b00, sq_r[2]};
      big_r <= big3_r;
    end
  end

endmodule

FILE: design/voxel_in_sphere_union_test_unit.sv
// ----------------------------------------------------------------------------
// voxel_in_sphere_union_test_unit: voxel against union of spheres
// tests voxel centres against up to MAX_CENTERS stored sphere centres
// ----------------------------------------------------------------------------
// One beat enters per clock when out_stall stays low. A test beat
// (func = 1) runs through five register stages to its hit beat: stage 1
// forms the voxel centre (one 21x17 multiply per axis), stage 2 the
// delta magnitudes, stage 3 the squares (three 32x32 multipliers in each
// centre cell), stage 4 the sum of squares and the output register the
// compare against radius_squared and the OR over the active cells. A
// centre write (func = 0) gives no beat; it lands in its cell as it
// leaves stage 1, so every test sees exactly the writes taken before it.
// All MAX_CENTERS cells work in parallel; cell i takes part when
// center_count is above i. Slots never written read as anything. The user
// must write configuration only while no beat is in flight; the block
// does not enforce it. A write to an unused register index is ignored.
// ----------------------------------------------------------------------------
module voxel_in_sphere_union_test_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // input beats
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_func,
  input  logic [vist_pkg::IDX_W-1:0]          in_center_index,
  input  logic signed [vist_pkg::COORD_W-1:0] in_center_x,
  input  logic signed [vist_pkg::COORD_W-1:0] in_center_y,
  input  logic signed [vist_pkg::COORD_W-1:0] in_center_z,
  input  logic signed [vist_pkg::VOX_W-1:0]   in_voxel_x,
  input  logic signed [vist_pkg::VOX_W-1:0]   in_voxel_y,
  input  logic signed [vist_pkg::VOX_W-1:0]   in_voxel_z,
  // result beats
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  // configuration
  input  logic                                cfg_we,
  input  logic [vist_pkg::CFG_A_W-1:0]        cfg_index,
  input  logic [vist_pkg::CFG_D_W-1:0]        cfg_wdata
);
  import vist_pkg::*;

  // configuration registers
  logic [VSIZE_W-1:0] cfg_voxel_size_r;
  logic [RAD_W-1:0]   cfg_radius_r;
  logic [CNT_W-1:0]   cfg_count_r;

  // pipeline valid bits
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_valid_r;

  // stage 1 payload
  logic             s1_func_r;
  logic [IDX_W-1:0] s1_idx_r;
  coord3_t          s1_center_r;
  vc3_t             s1_vc_r;
  vc3_t             s1_vc_nxt;

  logic out_hit_r;
  logic out_hit_nxt;

  // stage ready chain, back from the output register
  logic rdy_out, rdy4, rdy3, rdy2, rdy1;

  logic [MAX_CENTERS-1:0] lane_hit;
  sum_t                   lane_sum [MAX_CENTERS];
  logic [MAX_CENTERS-1:0] lane_big;

  assign rdy_out = !out_valid_r || !out_stall;
  assign rdy4    = !s4_v_r || rdy_out;
  assign rdy3    = !s3_v_r || rdy4;
  assign rdy2    = !s2_v_r || rdy3;
  assign rdy1    = !s1_v_r || rdy2;

  assign in_stall  = !rdy1;
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_voxel_size_r <= VOXEL_SIZE_RST;
      cfg_radius_r     <= '0;
      cfg_count_r      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VOXEL_SIZE:     cfg_voxel_size_r <= cfg_wdata[VSIZE_W-1:0];
        CFG_RADIUS_SQUARED: cfg_radius_r     <= cfg_wdata[RAD_W-1:0];
        CFG_CENTER_COUNT:   cfg_count_r      <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // voxel centre in Q.9: (2*index + 1) * voxel_size
  always_comb begin
    logic signed [VOX_W:0]       odd [3];
    logic signed [VSIZE_W:0]     vs;
    logic signed [VOX_W+VSIZE_W+1:0] prod;
    odd[0] = {in_voxel_x, 1'b1};
    odd[1] = {in_voxel_y, 1'b1};
    odd[2] = {in_voxel_z, 1'b1};
    vs     = {1'b0, cfg_voxel_size_r};
    for (int k = 0; k < 3; k++) begin
      prod         = odd[k] * vs;
      s1_vc_nxt[k] = prod[VC_W-1:0];
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_func_r   <= in_func;
      s1_idx_r    <= in_center_index;
      s1_center_r <= {in_center_z, in_center_y, in_center_x};
      s1_vc_r     <= s1_vc_nxt;
    end
  end

  // only test beats go past stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy2) begin
        s2_v_r <= s1_v_r && (s1_func_r == FUNC_TEST);
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
      if (rdy4) begin
        s4_v_r <= s3_v_r;
      end
      if (rdy_out) begin
        out_valid_r <= s4_v_r;
      end
    end
  end

  // centre cells
  for (genvar i = 0; i < MAX_CENTERS; i++) begin : g_lane
    adv_t adv;

    // a write beat stores into its slot as it leaves stage 1
    assign adv.wr  = s1_v_r && (s1_func_r == FUNC_WRITE) && rdy2
                     && (32'(s1_idx_r) == i);
    assign adv.en2 = rdy2;
    assign adv.en3 = rdy3;
    assign adv.en4 = rdy4;

    vist_lane u_lane (
      .clk       (clk),
      .adv       (adv),
      .wr_center (s1_center_r),
      .vc        (s1_vc_r),
      .sum_r     (lane_sum[i]),
      .big_r     (lane_big[i])
    );

    // a saturated square always exceeds the 63-bit radius
    assign lane_hit[i] = (32'(cfg_count_r) > i) && !lane_big[i]
                         && (lane_sum[i] <= {3'b000, cfg_radius_r});
  end

  assign out_hit_nxt = |lane_hit;

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_hit_r <= out_hit_nxt;
    end
  end

  // a result beat only ever comes out of stage 4
  a_out_from_s4: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s4_v_r))
    else $error("result beat without a stage 4 beat");

  // a write beat leaving stage 1 never becomes a result
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && (s1_func_r == FUNC_WRITE) && rdy2) |=> !s2_v_r)
    else $error("write beat entered the test stages");

  // the input stalls only while stage 1 holds a beat it cannot pass on
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && s3_v_r && s4_v_r && out_valid_r))
    else $error("input stalled with room in the pipeline");

endmodule
